// ===== rtl/qws_pkg.sv =====
// ----------------------------------------------------------------------------
// qws_pkg
// Types and constants shared by the quote-aware word splitter modules.
// ----------------------------------------------------------------------------
package qws_pkg;

  localparam logic [7:0]  BACKSLASH     = 8'h5C;
  localparam int unsigned MAX_PAIRS     = 4;
  localparam int unsigned MAX_RESULTS   = 3;

  // separator map 0 reset: tab, newline, space
  localparam logic [63:0] SEP_MAP0_RST  = 64'h0000_0001_0000_0600;

  // configuration register indexes
  localparam logic [2:0] REG_SEP_MAP0   = 3'd0;
  localparam logic [2:0] REG_SEP_MAP1   = 3'd1;
  localparam logic [2:0] REG_SEP_MAP2   = 3'd2;
  localparam logic [2:0] REG_SEP_MAP3   = 3'd3;
  localparam logic [2:0] REG_OPEN_QUOTE = 3'd4;
  localparam logic [2:0] REG_CLOSE_QUOTE = 3'd5;
  localparam logic [2:0] REG_PAIR_COUNT = 3'd6;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_WORD_END = 2'd1,
    KIND_STR_END  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    SCAN_IDLE  = 3'b001,
    SCAN_WORD  = 3'b010,
    SCAN_QUOTE = 3'b100
  } scan_mode_t;

  typedef struct packed {
    scan_mode_t  mode;
    logic [1:0]  pair;
    logic        esc;
  } scan_state_t;

  typedef struct packed {
    logic [255:0] sep_map;
    logic [31:0]  open_bytes;
    logic [31:0]  close_bytes;
    logic [2:0]   pair_count;
  } qws_cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  char_out;
    logic        last_of_run;
  } qws_result_t;

endpackage

// ===== rtl/qws_classify.sv =====
// ----------------------------------------------------------------------------
// qws_classify
// Classifies one byte against the current scan state and produces up to
// three results plus the next scan state.
// ----------------------------------------------------------------------------
module qws_classify import qws_pkg::*; #(
  parameter int QUOTE_PAIRS = 4
) (
  input  logic                          [7:0] char_in,
  input  logic                                last_char,
  input  scan_state_t                         state,
  input  qws_cfg_t                            cfg,
  output scan_state_t                         state_nxt,
  output qws_result_t [MAX_RESULTS-1:0]       res,
  output logic                          [1:0] res_cnt
);

  localparam int         LANES      = (QUOTE_PAIRS < MAX_PAIRS) ? QUOTE_PAIRS : MAX_PAIRS;
  localparam logic [2:0] LANE_LIMIT = 3'(LANES);

  logic        is_sep;
  logic [2:0]  pairs_used;
  logic        found;
  logic [1:0]  found_idx;
  logic [7:0]  close_byte;
  logic        main_emit;
  qws_result_t main_res;
  scan_state_t st;
  logic [1:0]  cnt;

  assign is_sep     = cfg.sep_map[char_in];
  assign pairs_used = (cfg.pair_count > LANE_LIMIT) ? LANE_LIMIT : cfg.pair_count;
  assign close_byte = cfg.close_bytes[{state.pair, 3'b000} +: 8];

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int p = 0; p < LANES; p++) begin
      if (!found && (3'(p) < pairs_used) && (char_in == cfg.open_bytes[p*8 +: 8])) begin
        found     = 1'b1;
        found_idx = 2'(p);
      end
    end
  end

  always_comb begin
    st        = state;
    main_emit = 1'b0;
    main_res  = '{kind: KIND_DATA, char_out: char_in, last_of_run: 1'b0};
    if (state.mode == SCAN_WORD || state.mode == SCAN_QUOTE) begin
      main_emit = 1'b1;
      if (state.esc) begin
        st.esc = 1'b0;
      end else if (char_in == BACKSLASH) begin
        st.esc = 1'b1;
      end else if (state.mode == SCAN_QUOTE && char_in == close_byte) begin
        main_res = '{kind: KIND_WORD_END, char_out: 8'd0, last_of_run: 1'b0};
        st.mode  = SCAN_IDLE;
        st.pair  = '0;
      end else if (state.mode == SCAN_WORD && is_sep) begin
        main_res = '{kind: KIND_WORD_END, char_out: 8'd0, last_of_run: 1'b0};
        st.mode  = SCAN_IDLE;
      end
    end else begin
      st.mode = SCAN_IDLE;
      if (!is_sep) begin
        if (found) begin
          st.mode = SCAN_QUOTE;
          st.pair = found_idx;
        end else begin
          main_emit = 1'b1;
          st.mode   = SCAN_WORD;
        end
      end
    end
  end

  always_comb begin
    res       = '0;
    cnt       = 2'd0;
    state_nxt = st;
    if (main_emit) begin
      res[0] = main_res;
      cnt    = 2'd1;
    end
    if (last_char) begin
      if (st.mode == SCAN_WORD || st.mode == SCAN_QUOTE) begin
        res[cnt] = '{kind: KIND_WORD_END, char_out: 8'd0, last_of_run: 1'b0};
        cnt      = cnt + 2'd1;
      end
      res[cnt]  = '{kind: KIND_STR_END, char_out: 8'd0, last_of_run: 1'b0};
      cnt       = cnt + 2'd1;
      state_nxt = '{mode: SCAN_IDLE, pair: 2'd0, esc: 1'b0};
    end
    if (cnt != 2'd0) begin
      res[cnt - 2'd1].last_of_run = 1'b1;
    end
    res_cnt = cnt;
  end

endmodule

// ===== rtl/quote_aware_word_splitter.sv =====
// ----------------------------------------------------------------------------
// quote_aware_word_splitter
// Splits a byte stream into words with separator map, quote pairs and
// backslash escapes; emits data bytes, word ends and string ends.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_stall   | in_char_in, in_last_char
//   out     | output    | out_valid/out_stall | out_kind, out_char_out, out_last_of_run
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A byte is classified in the cycle it is accepted and its zero to three
// results are written into a four-entry result queue; one result leaves per
// cycle while out_stall is low. A byte is accepted whenever the queue holds
// at most one result, so single-result bytes stream at one per cycle while
// out_stall is low; a multi-result byte holds off input until the queue again
// holds at most one result. Reset is synchronous, active low; cfg_ready is always high.
// ----------------------------------------------------------------------------
module quote_aware_word_splitter import qws_pkg::*; #(
  parameter int QUOTE_PAIRS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_char_out,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  qws_cfg_t                      cfg_r;
  scan_state_t                   state_r;
  scan_state_t                   state_nxt;
  qws_result_t [MAX_RESULTS-1:0] res;
  logic [1:0]                    res_cnt;
  qws_result_t [3:0]             queue_r;
  logic [1:0]                    head_r;
  logic [2:0]                    count_r;
  logic [2:0]                    count_nxt;
  logic [1:0]                    tail;
  logic                          push;
  logic                          pop;

  qws_classify #(
    .QUOTE_PAIRS (QUOTE_PAIRS)
  ) u_classify (
    .char_in   (in_char_in),
    .last_char (in_last_char),
    .state     (state_r),
    .cfg       (cfg_r),
    .state_nxt (state_nxt),
    .res       (res),
    .res_cnt   (res_cnt)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (count_r > 3'd1);
  assign push      = in_valid && !in_stall;
  assign out_valid = (count_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign tail      = head_r + count_r[1:0];

  assign out_kind        = queue_r[head_r].kind;
  assign out_char_out    = queue_r[head_r].char_out;
  assign out_last_of_run = queue_r[head_r].last_of_run;

  always_comb begin
    count_nxt = count_r;
    if (push) begin
      count_nxt = count_nxt + {1'b0, res_cnt};
    end
    if (pop) begin
      count_nxt = count_nxt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sep_map     <= {192'd0, SEP_MAP0_RST};
      cfg_r.open_bytes  <= '0;
      cfg_r.close_bytes <= '0;
      cfg_r.pair_count  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SEP_MAP0:    cfg_r.sep_map[63:0]    <= cfg_data;
        REG_SEP_MAP1:    cfg_r.sep_map[127:64]  <= cfg_data;
        REG_SEP_MAP2:    cfg_r.sep_map[191:128] <= cfg_data;
        REG_SEP_MAP3:    cfg_r.sep_map[255:192] <= cfg_data;
        REG_OPEN_QUOTE:  cfg_r.open_bytes       <= cfg_data[31:0];
        REG_CLOSE_QUOTE: cfg_r.close_bytes      <= cfg_data[31:0];
        REG_PAIR_COUNT:  cfg_r.pair_count       <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{mode: SCAN_IDLE, pair: 2'd0, esc: 1'b0};
      head_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        state_r <= state_nxt;
      end
      if (pop) begin
        head_r <= head_r + 2'd1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        if (2'(i) < res_cnt) begin
          queue_r[tail + 2'(i)] <= res[i];
        end
      end
    end
  end

endmodule
